@@ hdl/breakpoint_table_toggle_find_assert.svh @@
// assertion macros used by the breakpoint table checker
`ifndef BREAKPOINT_TABLE_TOGGLE_FIND_ASSERT_SVH
`define BREAKPOINT_TABLE_TOGGLE_FIND_ASSERT_SVH

// same-cycle implication, sampled on clk, idle in reset
`define BTTF_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bttf check failed");

// next-cycle implication, sampled on clk, idle in reset
`define BTTF_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bttf check failed");

`endif

@@ hdl/bttf_pkg.sv @@
// types, codes and constants of the breakpoint table
package bttf_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int ADDR_W      = 16;
    localparam int FLAG_W      = 8;
    localparam int SLOT_W      = 6;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 2;

    typedef enum logic [1:0] {
        OP_WRITE  = 2'd0,
        OP_TOGGLE = 2'd1,
        OP_FIND   = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_OPCODE = 2'd1,
        KIND_DATA   = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        ST_WRITTEN  = 3'd0,
        ST_REMOVED  = 3'd1,
        ST_ADDED    = 3'd2,
        ST_FOUND    = 3'd3,
        ST_NOTFOUND = 3'd4,
        ST_ERROR    = 3'd5
    } status_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_EXEC  = 2'd0,
        CFG_LOAD  = 2'd1,
        CFG_STORE = 2'd2,
        CFG_TYPE  = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]        operation;
        logic [SLOT_W-1:0] slot_index;
        logic [ADDR_W-1:0] address_in;
        logic [FLAG_W-1:0] mask_in;
        logic [1:0]        symbol_kind;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   entry_index;
        logic [ADDR_W-1:0]   entry_address;
        logic [FLAG_W-1:0]   entry_flags;
    } rsp_t;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] reg_index;
        logic [FLAG_W-1:0]    wr_data;
    } cfg_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [FLAG_W-1:0] flags;
    } entry_t;

endpackage

@@ hdl/bttf_chan_if.sv @@
// valid/ready channel carrying one payload beat
interface bttf_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

@@ hdl/bttf_store.sv @@
// breakpoint entry memory with per-entry valid bits and registered read
module bttf_store #(
    parameter int ENTRIES = bttf_pkg::ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       wr_en,
    input  logic [$clog2(ENTRIES)-1:0] wr_idx,
    input  bttf_pkg::entry_t           wr_entry,
    input  logic                       rd_en,
    input  logic [$clog2(ENTRIES)-1:0] rd_idx,
    output bttf_pkg::entry_t           rd_entry
);
    import bttf_pkg::*;

    entry_t             entry_ram [ENTRIES];
    entry_t             rd_data_reg;
    logic [ENTRIES-1:0] valid_reg;
    logic               rd_valid_reg;

    // memory array, one write and one read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_ram[wr_idx] <= wr_entry;
        end
        if (rd_en)
        begin
            rd_data_reg <= entry_ram[rd_idx];
        end
    end

    // written marks, an unwritten entry reads as empty
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_idx];
            end
        end
    end

    assign rd_entry = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ hdl/bttf_ctrl.sv @@
// sequencer: forward match scan, backward shrink scan, config and result beat
module bttf_ctrl #(
    parameter int ENTRIES = bttf_pkg::ENTRIES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cmd_valid,
    output logic                       cmd_ready,
    input  bttf_pkg::cmd_t             cmd_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  bttf_pkg::cfg_t             cfg_data,
    output logic                       rsp_valid,
    input  logic                       rsp_ready,
    output bttf_pkg::rsp_t             rsp_data,
    output logic                       mem_wr_en,
    output logic [$clog2(ENTRIES)-1:0] mem_wr_idx,
    output bttf_pkg::entry_t           mem_wr_entry,
    output logic                       mem_rd_en,
    output logic [$clog2(ENTRIES)-1:0] mem_rd_idx,
    input  bttf_pkg::entry_t           mem_rd_entry
);
    import bttf_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHRINK,
        S_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic [FLAG_W-1:0]   exec_reg, exec_next;
    logic [FLAG_W-1:0]   load_reg, load_next;
    logic [FLAG_W-1:0]   store_reg, store_next;
    logic [FLAG_W-1:0]   type_bits_reg, type_bits_next;
    logic [1:0]          op_reg, op_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [FLAG_W-1:0]   mask_reg, mask_next;
    logic [FLAG_W-1:0]   type_reg, type_next;
    logic [1:0]          kind_reg, kind_next;
    logic [CNT_W-1:0]    ptr_reg, ptr_next;
    logic [CNT_W-1:0]    keep_reg, keep_next;
    logic                pend_reg, pend_next;
    logic [IDX_W-1:0]    cmp_idx_reg, cmp_idx_next;
    status_t             res_status_reg, res_status_next;
    logic [SLOT_W-1:0]   res_idx_reg, res_idx_next;
    entry_t              res_entry_reg, res_entry_next;
    logic                out_valid_reg, out_valid_next;
    rsp_t                out_reg, out_next;

    logic                hit;
    logic                stop;
    logic [CNT_W-1:0]    keep_eff;
    logic [CNT_W-1:0]    target;
    logic [FLAG_W-1:0]   add_flags;

    assign cmd_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign rsp_valid = out_valid_reg;
    assign rsp_data  = out_reg;

    // match of the entry read in the previous cycle
    assign hit = pend_reg && (mem_rd_entry.flags != '0)
                 && (mem_rd_entry.address == addr_reg)
                 && ((mem_rd_entry.flags & type_bits_reg) == type_reg);

    // slot and flags for an added entry
    assign target = (cnt_reg == '0) ? CNT_W'(1) : cnt_reg;

    always_comb
    begin
        unique case (kind_reg)
            KIND_NONE:   add_flags = mask_reg | exec_reg | load_reg | store_reg;
            KIND_OPCODE: add_flags = mask_reg | exec_reg;
            default:     add_flags = mask_reg | load_reg | store_reg;
        endcase
    end

    // next state and datapath
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        exec_next       = exec_reg;
        load_next       = load_reg;
        store_next      = store_reg;
        type_bits_next  = type_bits_reg;
        op_next         = op_reg;
        addr_next       = addr_reg;
        mask_next       = mask_reg;
        type_next       = type_reg;
        kind_next       = kind_reg;
        ptr_next        = ptr_reg;
        keep_next       = keep_reg;
        pend_next       = pend_reg;
        cmp_idx_next    = cmp_idx_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_entry_next  = res_entry_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        mem_wr_en       = 1'b0;
        mem_wr_idx      = '0;
        mem_wr_entry    = '0;
        mem_rd_en       = 1'b0;
        mem_rd_idx      = '0;
        stop            = 1'b0;
        keep_eff        = keep_reg;

        // configuration beat
        if (cfg_valid)
        begin
            unique case (cfg_data.reg_index)
                CFG_EXEC:  exec_next      = cfg_data.wr_data;
                CFG_LOAD:  load_next      = cfg_data.wr_data;
                CFG_STORE: store_next     = cfg_data.wr_data;
                CFG_TYPE:  type_bits_next = cfg_data.wr_data;
                default:   exec_next      = exec_reg;
            endcase
        end

        // result beat taken downstream
        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    op_next   = cmd_data.operation;
                    addr_next = cmd_data.address_in;
                    mask_next = cmd_data.mask_in;
                    type_next = cmd_data.mask_in & type_bits_reg;
                    kind_next = cmd_data.symbol_kind;
                    ptr_next  = '0;
                    pend_next = 1'b0;
                    unique case (cmd_data.operation)
                        OP_WRITE:
                        begin
                            if (int'(cmd_data.slot_index) >= ENTRIES)
                            begin
                                res_status_next = ST_ERROR;
                                res_idx_next    = '0;
                                res_entry_next  = '0;
                                state_next      = S_RESP;
                            end
                            else
                            begin
                                mem_wr_en              = 1'b1;
                                mem_wr_idx             = IDX_W'(cmd_data.slot_index);
                                mem_wr_entry.address   = cmd_data.address_in;
                                mem_wr_entry.flags     = cmd_data.mask_in;
                                res_status_next        = ST_WRITTEN;
                                res_idx_next           = cmd_data.slot_index;
                                res_entry_next.address = cmd_data.address_in;
                                res_entry_next.flags   = cmd_data.mask_in;
                                if (cmd_data.mask_in == '0)
                                begin
                                    keep_next  = cnt_reg;
                                    ptr_next   = cnt_reg;
                                    state_next = S_SHRINK;
                                end
                                else
                                begin
                                    if (int'(cmd_data.slot_index) >= int'(cnt_reg))
                                    begin
                                        cnt_next = CNT_W'(cmd_data.slot_index) + CNT_W'(1);
                                    end
                                    state_next = S_RESP;
                                end
                            end
                        end
                        OP_TOGGLE, OP_FIND:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            res_status_next = ST_ERROR;
                            res_idx_next    = '0;
                            res_entry_next  = '0;
                            state_next      = S_RESP;
                        end
                    endcase
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    res_idx_next = SLOT_W'(cmp_idx_reg);
                    if (op_reg == OP_FIND)
                    begin
                        res_status_next = ST_FOUND;
                        res_entry_next  = mem_rd_entry;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        // remove the hit, then pull the count back
                        mem_wr_en       = 1'b1;
                        mem_wr_idx      = cmp_idx_reg;
                        res_status_next = ST_REMOVED;
                        res_entry_next  = '0;
                        keep_next       = cnt_reg;
                        ptr_next        = cnt_reg;
                        pend_next       = 1'b0;
                        state_next      = S_SHRINK;
                    end
                end
                else if (ptr_reg < cnt_reg)
                begin
                    // issue the next read, compare it next cycle
                    mem_rd_en    = 1'b1;
                    mem_rd_idx   = IDX_W'(ptr_reg);
                    cmp_idx_next = IDX_W'(ptr_reg);
                    pend_next    = 1'b1;
                    ptr_next     = ptr_reg + CNT_W'(1);
                end
                else if (op_reg == OP_FIND)
                begin
                    res_status_next = ST_NOTFOUND;
                    res_idx_next    = '0;
                    res_entry_next  = '0;
                    state_next      = S_RESP;
                end
                else if (int'(target) >= ENTRIES)
                begin
                    res_status_next = ST_ERROR;
                    res_idx_next    = '0;
                    res_entry_next  = '0;
                    state_next      = S_RESP;
                end
                else
                begin
                    // no match: add at the count, or at slot 1 while the count is zero
                    mem_wr_en              = 1'b1;
                    mem_wr_idx             = IDX_W'(target);
                    mem_wr_entry.address   = addr_reg;
                    mem_wr_entry.flags     = add_flags;
                    res_status_next        = ST_ADDED;
                    res_idx_next           = SLOT_W'(target);
                    res_entry_next.address = addr_reg;
                    res_entry_next.flags   = add_flags;
                    if (add_flags == '0)
                    begin
                        keep_next  = cnt_reg;
                        ptr_next   = cnt_reg;
                        pend_next  = 1'b0;
                        state_next = S_SHRINK;
                    end
                    else
                    begin
                        cnt_next   = target + CNT_W'(1);
                        state_next = S_RESP;
                    end
                end
            end

            S_SHRINK:
            begin
                // check the entry read last cycle, walking down
                if (pend_reg)
                begin
                    if (mem_rd_entry.flags != '0)
                    begin
                        stop = 1'b1;
                    end
                    else
                    begin
                        keep_eff = keep_reg - CNT_W'(1);
                    end
                end
                if (!stop && (ptr_reg != '0))
                begin
                    mem_rd_en  = 1'b1;
                    mem_rd_idx = IDX_W'(ptr_reg - CNT_W'(1));
                    ptr_next   = ptr_reg - CNT_W'(1);
                    pend_next  = 1'b1;
                    keep_next  = keep_eff;
                end
                else
                begin
                    cnt_next   = keep_eff;
                    pend_next  = 1'b0;
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_valid_next         = 1'b1;
                    out_next.status        = res_status_reg;
                    out_next.entry_index   = res_idx_reg;
                    out_next.entry_address = res_entry_reg.address;
                    out_next.entry_flags   = res_entry_reg.flags;
                    state_next             = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // state, count, config and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            cnt_reg        <= '0;
            exec_reg       <= FLAG_W'(1);
            load_reg       <= FLAG_W'(2);
            store_reg      <= FLAG_W'(4);
            type_bits_reg  <= FLAG_W'(128);
            op_reg         <= '0;
            addr_reg       <= '0;
            mask_reg       <= '0;
            type_reg       <= '0;
            kind_reg       <= '0;
            ptr_reg        <= '0;
            keep_reg       <= '0;
            pend_reg       <= 1'b0;
            cmp_idx_reg    <= '0;
            res_status_reg <= ST_WRITTEN;
            res_idx_reg    <= '0;
            res_entry_reg  <= '0;
            out_valid_reg  <= 1'b0;
            out_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            exec_reg       <= exec_next;
            load_reg       <= load_next;
            store_reg      <= store_next;
            type_bits_reg  <= type_bits_next;
            op_reg         <= op_next;
            addr_reg       <= addr_next;
            mask_reg       <= mask_next;
            type_reg       <= type_next;
            kind_reg       <= kind_next;
            ptr_reg        <= ptr_next;
            keep_reg       <= keep_next;
            pend_reg       <= pend_next;
            cmp_idx_reg    <= cmp_idx_next;
            res_status_reg <= res_status_next;
            res_idx_reg    <= res_idx_next;
            res_entry_reg  <= res_entry_next;
            out_valid_reg  <= out_valid_next;
            out_reg        <= out_next;
        end
    end

endmodule

@@ hdl/breakpoint_table_toggle_find.sv @@
// Breakpoint table with write, toggle and find commands.
// cmd (sink): one beat per command: operation, slot_index, address_in,
//   mask_in, symbol_kind. cmd.ready is high only while no command is in work.
// rsp (source): one beat per command: status, entry_index, entry_address,
//   entry_flags. A finished beat sits in an output register, so the next
//   command is taken while rsp is stalled; the sequencer waits before
//   delivering a second result until that register has been taken.
// cfg (sink): always ready; reg_index 0..3 selects exec, load, store and
//   type mask bits; write it only while no command is in work.
// Work per accepted command:
//   write, non-empty mask:  no scan
//   write, empty mask:      backward shrink scan
//   find:                   forward scan
//   toggle:                 forward scan, then shrink after a removal or an empty add
// Both scans read one entry per cycle through the single read port of the
// entry memory.
// Reset: config returns to 1/2/4/128, the used count to zero and every entry
//   reads empty at once through per-entry valid bits; no clearing pass.
module breakpoint_table_toggle_find #(
    parameter int ENTRIES = bttf_pkg::ENTRIES_DEF
) (
    input logic        clk,
    input logic        rst_n,
    bttf_chan_if.sink   cmd,
    bttf_chan_if.source rsp,
    bttf_chan_if.sink   cfg
);
    import bttf_pkg::*;

    localparam int IDX_W = $clog2(ENTRIES);

    logic             mem_wr_en;
    logic [IDX_W-1:0] mem_wr_idx;
    entry_t           mem_wr_entry;
    logic             mem_rd_en;
    logic [IDX_W-1:0] mem_rd_idx;
    entry_t           mem_rd_entry;
    cmd_t             cmd_data;
    cfg_t             cfg_data;
    rsp_t             rsp_data;

    assign cmd_data = cmd.data;
    assign cfg_data = cfg.data;
    assign rsp.data = rsp_data;

    // command sequencer
    bttf_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd.valid),
        .cmd_ready    (cmd.ready),
        .cmd_data     (cmd_data),
        .cfg_valid    (cfg.valid),
        .cfg_ready    (cfg.ready),
        .cfg_data     (cfg_data),
        .rsp_valid    (rsp.valid),
        .rsp_ready    (rsp.ready),
        .rsp_data     (rsp_data),
        .mem_wr_en    (mem_wr_en),
        .mem_wr_idx   (mem_wr_idx),
        .mem_wr_entry (mem_wr_entry),
        .mem_rd_en    (mem_rd_en),
        .mem_rd_idx   (mem_rd_idx),
        .mem_rd_entry (mem_rd_entry)
    );

    // entry memory
    bttf_store #(
        .ENTRIES (ENTRIES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (mem_wr_en),
        .wr_idx   (mem_wr_idx),
        .wr_entry (mem_wr_entry),
        .rd_en    (mem_rd_en),
        .rd_idx   (mem_rd_idx),
        .rd_entry (mem_rd_entry)
    );

endmodule

@@ hdl/bttf_checker.sv @@
// port-level checks of the breakpoint table and their bind
`include "breakpoint_table_toggle_find_assert.svh"

module bttf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic [bttf_pkg::STATUS_W-1:0] rsp_status,
    input logic [bttf_pkg::SLOT_W-1:0]   rsp_index,
    input logic [bttf_pkg::ADDR_W-1:0]   rsp_address,
    input logic [bttf_pkg::FLAG_W-1:0]   rsp_flags
);
    import bttf_pkg::*;

    localparam int BEAT_W = STATUS_W + SLOT_W + ADDR_W + FLAG_W;

    logic              rsp_stall;
    logic              rsp_miss;
    logic              rsp_removed;
    logic [BEAT_W-1:0] rsp_beat;

    // beat qualifiers
    assign rsp_stall   = rsp_valid && !rsp_ready;
    assign rsp_miss    = rsp_valid && (rsp_status == ST_NOTFOUND || rsp_status == ST_ERROR);
    assign rsp_removed = rsp_valid && (rsp_status == ST_REMOVED);
    assign rsp_beat    = {rsp_status, rsp_index, rsp_address, rsp_flags};

    // a stalled result beat stays and holds its payload
    `BTTF_ASSERT_NXT(a_rsp_hold, rsp_stall, rsp_valid)
    `BTTF_ASSERT_NXT(a_rsp_stable, rsp_stall, $stable(rsp_beat))

    // miss and error beats carry no entry
    `BTTF_ASSERT_IMP(a_miss_zero, rsp_miss, rsp_index == '0 && rsp_address == '0 && rsp_flags == '0)

    // a removed entry is reported empty
    `BTTF_ASSERT_IMP(a_removed_empty, rsp_removed, rsp_address == '0 && rsp_flags == '0)

    // find only reports a live entry
    `BTTF_ASSERT_IMP(a_found_live, rsp_valid && rsp_status == ST_FOUND, rsp_flags != '0)

endmodule

bind breakpoint_table_toggle_find bttf_checker u_bttf_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .rsp_status  (rsp.data.status),
    .rsp_index   (rsp.data.entry_index),
    .rsp_address (rsp.data.entry_address),
    .rsp_flags   (rsp.data.entry_flags)
);
